[hw/rtl/cnrt_pkg.sv]
// Package for the channel name rule translator: widths, opcodes, status codes,
// name normalization helpers and the wildcard mark type. No dependencies.
package cnrt_pkg;

  localparam int RULE_ENTRIES = 64;
  localparam int IDX_W = $clog2(RULE_ENTRIES);
  localparam int CNT_W = $clog2(RULE_ENTRIES + 1);

  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_QUEST = 8'h3F;

  typedef enum logic [0:0] {
    OP_INSERT = 1'b0,
    OP_LOOKUP = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOMATCH = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef struct packed {
    logic [39:0] sta;
    logic [15:0] net;
    logic [23:0] cha;
    logic [15:0] loc;
  } names_t;

  // Wild marks: [0] sta, [1] net, [2] cha, [3] third cha '?', [4] loc.
  typedef logic [4:0] marks_t;

  // Classified item handed from front to back.
  typedef struct packed {
    opcode_t op;
    names_t  key;
    names_t  map;
    marks_t  marks;
  } job_t;

  typedef struct packed {
    status_t st;
    names_t  nm;
  } result_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_EXACT,
    BK_WILD,
    BK_DONE
  } back_state_t;

  function automatic logic [39:0] norm5(input logic [39:0] v);
    logic [39:0] r;
    logic        alive;
    r = '0;
    alive = 1'b1;
    for (int i = 4; i >= 0; i--) begin
      if (v[i*8 +: 8] == 8'h00) alive = 1'b0;
      if (alive) r[i*8 +: 8] = v[i*8 +: 8];
    end
    return r;
  endfunction

  function automatic logic [23:0] norm3(input logic [23:0] v);
    logic [23:0] r;
    logic        alive;
    r = '0;
    alive = 1'b1;
    for (int i = 2; i >= 0; i--) begin
      if (v[i*8 +: 8] == 8'h00) alive = 1'b0;
      if (alive) r[i*8 +: 8] = v[i*8 +: 8];
    end
    return r;
  endfunction

  function automatic logic [15:0] norm2(input logic [15:0] v);
    logic [15:0] r;
    r = '0;
    if (v[15:8] != 8'h00) begin
      r[15:8] = v[15:8];
      if (v[7:0] != 8'h00) r[7:0] = v[7:0];
    end
    return r;
  endfunction

endpackage

[hw/rtl/cnrt_front.sv]
// Front end: takes items, normalizes names, computes wild marks, and holds
// them in a two-entry queue for the back end. Uses cnrt_pkg.
module cnrt_front import cnrt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic        in_opcode,
  input  logic [39:0] in_key_station,
  input  logic [15:0] in_key_network,
  input  logic [23:0] in_key_channel,
  input  logic [15:0] in_key_location,
  input  logic [39:0] in_map_station,
  input  logic [15:0] in_map_network,
  input  logic [23:0] in_map_channel,
  input  logic [15:0] in_map_location,
  output logic        job_valid,
  output job_t        job,
  input  logic        job_take
);

  job_t        q_r [2];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r;
  job_t        cls;
  logic        wr;

  always_comb begin
    cls.op      = opcode_t'(in_opcode);
    cls.key.sta = norm5(in_key_station);
    cls.key.net = norm2(in_key_network);
    cls.key.cha = norm3(in_key_channel);
    cls.key.loc = norm2(in_key_location);
    cls.map.sta = norm5(in_map_station);
    cls.map.net = norm2(in_map_network);
    cls.map.cha = norm3(in_map_channel);
    cls.map.loc = norm2(in_map_location);
    cls.marks[0] = (cls.key.sta == {CH_STAR, 32'h0});
    cls.marks[1] = (cls.key.net == {CH_STAR, 8'h0});
    cls.marks[2] = (cls.key.cha == {CH_STAR, 16'h0});
    cls.marks[3] = (cls.key.cha[7:0] == CH_QUEST);
    cls.marks[4] = (cls.key.loc == {CH_STAR, 8'h0});
  end

  assign full      = (cnt_r == 2'd2);
  assign wr        = push && !full;
  assign job_valid = (cnt_r != 2'd0);
  assign job       = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr) q_r[wp_r] <= cls;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr) wp_r <= ~wp_r;
      if (job_take) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(wr) - 2'(job_take);
    end
  end

endmodule

[hw/rtl/cnrt_back.sv]
// Back end: rule memory, insert, and two-pass lookup scan (exact, then
// wildcard), one rule read per cycle; one-entry result register. Uses cnrt_pkg.
module cnrt_back import cnrt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        job_valid,
  input  job_t        job,
  output logic        job_take,
  output logic        res_valid,
  output result_t     res,
  input  logic        res_take
);

  typedef struct packed {
    names_t key;
    marks_t marks;
    names_t map;
  } rule_t;

  rule_t       mem [RULE_ENTRIES];
  rule_t       rd_r;
  logic        rd_v_r;
  logic [CNT_W-1:0] count_r, addr_r, addr_nxt;
  back_state_t st_r, st_nxt;
  job_t        cur_r;
  result_t     res_r, res_nxt;
  logic        res_v_r, res_v_nxt;
  logic        rd_v_nxt;
  logic        load, ins_wr, ex_hit, wd_hit;
  names_t      wout;

  assign res_valid = res_v_r;
  assign res       = res_r;

  // Exact and wildcard match of the rule read last cycle.
  always_comb begin
    ex_hit = (rd_r.marks == '0) && (rd_r.key == cur_r.key);
    wd_hit = (rd_r.marks != '0)
          && (rd_r.marks[0] || rd_r.key.sta == cur_r.key.sta)
          && (rd_r.marks[1] || rd_r.key.net == cur_r.key.net)
          && (rd_r.marks[2] ||
              (rd_r.marks[3] ? rd_r.key.cha[23:8] == cur_r.key.cha[23:8]
                             : rd_r.key.cha == cur_r.key.cha))
          && (rd_r.marks[4] || rd_r.key.loc == cur_r.key.loc);
    wout.sta = (rd_r.map.sta[39:32] == CH_STAR) ? cur_r.key.sta : rd_r.map.sta;
    wout.net = (rd_r.map.net[15:8] == CH_STAR) ? cur_r.key.net : rd_r.map.net;
    if (rd_r.map.cha[23:16] == CH_STAR) wout.cha = cur_r.key.cha;
    else if (rd_r.map.cha[7:0] == CH_QUEST)
      wout.cha = {rd_r.map.cha[23:8], cur_r.key.cha[7:0]};
    else wout.cha = rd_r.map.cha;
    wout.loc = (rd_r.map.loc[15:8] == CH_STAR) ? cur_r.key.loc : rd_r.map.loc;
  end

  always_comb begin
    st_nxt    = st_r;
    addr_nxt  = addr_r;
    rd_v_nxt  = 1'b0;
    res_nxt   = res_r;
    res_v_nxt = res_v_r && !res_take;
    job_take  = 1'b0;
    load      = 1'b0;
    ins_wr    = 1'b0;
    unique case (st_r)
      BK_IDLE: begin
        if (job_valid && !res_v_nxt) begin
          job_take = 1'b1;
          load     = 1'b1;
          res_nxt.nm = '0;
          if (job.op == OP_INSERT) begin
            res_v_nxt = 1'b1;
            if (count_r == CNT_W'(RULE_ENTRIES)) res_nxt.st = ST_FULL;
            else begin
              res_nxt.st = ST_OK;
              ins_wr = 1'b1;
            end
          end else begin
            addr_nxt = '0;
            st_nxt   = BK_EXACT;
          end
        end
      end
      BK_EXACT, BK_WILD: begin
        // Issue read at addr_r; check the previous read.
        if (rd_v_r && (st_r == BK_EXACT ? ex_hit : wd_hit)) begin
          res_nxt.st = ST_OK;
          res_nxt.nm = (st_r == BK_EXACT) ? rd_r.map : wout;
          st_nxt     = BK_DONE;
        end else if (addr_r < count_r) begin
          rd_v_nxt = 1'b1;
          addr_nxt = addr_r + 1'b1;
        end else if (st_r == BK_EXACT) begin
          addr_nxt = '0;
          st_nxt   = BK_WILD;
        end else begin
          res_nxt.st = ST_NOMATCH;
          res_nxt.nm = '0;
          st_nxt     = BK_DONE;
        end
      end
      BK_DONE: begin
        if (!res_v_nxt) begin
          res_v_nxt = 1'b1;
          st_nxt    = BK_IDLE;
        end
      end
      default: st_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ins_wr) mem[count_r[IDX_W-1:0]] <= '{key: job.key, marks: job.marks, map: job.map};
    rd_r <= mem[addr_r[IDX_W-1:0]];
    if (load) cur_r <= job;
    res_r <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= BK_IDLE;
      addr_r  <= '0;
      count_r <= '0;
      rd_v_r  <= 1'b0;
      res_v_r <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      addr_r  <= addr_nxt;
      rd_v_r  <= rd_v_nxt;
      res_v_r <= res_v_nxt;
      if (ins_wr) count_r <= count_r + 1'b1;
    end
  end

endmodule

[hw/rtl/channel_name_rule_translator_top.sv]
// Channel name rule translator, top level: queue-style ports on both sides.
// Instantiates cnrt_front and cnrt_back; uses cnrt_pkg.
//
// A lookup scans the rule memory, which holds up to 64 rules, once for exact
// rules and once more for wildcard rules, one read per cycle, and ends early
// at the first match; the single read port of the rule memory sets this pace.
// A two-entry queue lets new items be pushed while a lookup runs, and the
// result register holds an answer until popped.
module channel_name_rule_translator_top import cnrt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic        in_opcode,
  input  logic [39:0] in_key_station,
  input  logic [15:0] in_key_network,
  input  logic [23:0] in_key_channel,
  input  logic [15:0] in_key_location,
  input  logic [39:0] in_map_station,
  input  logic [15:0] in_map_network,
  input  logic [23:0] in_map_channel,
  input  logic [15:0] in_map_location,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  out_status,
  output logic [39:0] out_station,
  output logic [15:0] out_network,
  output logic [23:0] out_channel,
  output logic [15:0] out_location
);

  logic    job_valid, job_take, res_valid;
  job_t    job;
  result_t res;

  cnrt_front u_front (
    .clk, .rst_n, .push, .full,
    .in_opcode, .in_key_station, .in_key_network, .in_key_channel, .in_key_location,
    .in_map_station, .in_map_network, .in_map_channel, .in_map_location,
    .job_valid, .job, .job_take
  );

  cnrt_back u_back (
    .clk, .rst_n, .job_valid, .job, .job_take,
    .res_valid, .res, .res_take(pop && res_valid)
  );

  assign empty        = !res_valid;
  assign out_status   = res.st;
  assign out_station  = res.nm.sta;
  assign out_network  = res.nm.net;
  assign out_channel  = res.nm.cha;
  assign out_location = res.nm.loc;

endmodule

[hw/rtl/cnrt_checker.sv]
// Port-level checker for the channel name rule translator, bound to the top.
// Uses cnrt_pkg status codes.
module cnrt_checker import cnrt_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [1:0]  out_status,
  input logic [39:0] out_station
);

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_status == ST_OK || out_status == ST_NOMATCH || out_status == ST_FULL))
    else $error("bad status");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_status != ST_OK) |-> out_station == '0)
    else $error("names not zero on failure");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_status) && $stable(out_station)))
    else $error("result changed while waiting");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (empty && !full))
    else $error("not empty after reset");

endmodule

bind channel_name_rule_translator_top cnrt_checker u_cnrt_checker (
  .clk, .rst_n, .full, .empty, .pop, .out_status, .out_station
);

[tb/sv/channel_name_rule_translator_top_tb.sv]
// Testbench for channel_name_rule_translator_top: directed and random inserts
// and lookups checked against a behavioral rule table. Depends on cnrt_pkg.
`timescale 1ns / 100ps

module channel_name_rule_translator_top_tb;
  import cnrt_pkg::*;

  localparam int MAX_GAP = 18;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct {
    status_t st;
    names_t  nm;
  } answer_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic        in_opcode = 1'b0;
  logic [39:0] in_key_station = '0;
  logic [15:0] in_key_network = '0;
  logic [23:0] in_key_channel = '0;
  logic [15:0] in_key_location = '0;
  logic [39:0] in_map_station = '0;
  logic [15:0] in_map_network = '0;
  logic [23:0] in_map_channel = '0;
  logic [15:0] in_map_location = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [1:0]  out_status;
  logic [39:0] out_station;
  logic [15:0] out_network;
  logic [23:0] out_channel;
  logic [15:0] out_location;

  // rule table as the block should hold it
  names_t  tbl_key [RULE_ENTRIES];
  names_t  tbl_map [RULE_ENTRIES];
  marks_t  tbl_marks [RULE_ENTRIES];
  int      tbl_count = 0;
  answer_t pending_answers[$];
  int      mismatches = 0;
  int      cycles = 0;
  bit      quiet = 1'b0;

  channel_name_rule_translator_top dut (.*);

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic [39:0] trim_name(logic [39:0] v, int nb);
    logic [39:0] r;
    bit          live;
    r = '0;
    live = 1'b1;
    for (int i = nb - 1; i >= 0; i--) begin
      if (v[i*8 +: 8] == 8'h00) live = 1'b0;
      if (live) r[i*8 +: 8] = v[i*8 +: 8];
    end
    return r;
  endfunction

  function automatic bit lone_star(logic [39:0] v, int nb);
    logic [39:0] s;
    s = '0;
    s[(nb-1)*8 +: 8] = CH_STAR;
    return v == s;
  endfunction

  function automatic bit leads_star(logic [39:0] v, int nb);
    return v[(nb-1)*8 +: 8] == CH_STAR;
  endfunction

  // Apply one item to the rule table and return the answer it should give.
  function automatic answer_t translate(opcode_t op, names_t k_raw, names_t m_raw);
    answer_t a;
    names_t  k;
    marks_t  mk;
    bit      hit;
    k.sta = trim_name(k_raw.sta, 5);
    k.net = 16'(trim_name(40'(k_raw.net), 2));
    k.cha = 24'(trim_name(40'(k_raw.cha), 3));
    k.loc = 16'(trim_name(40'(k_raw.loc), 2));
    a.st = ST_OK;
    a.nm = '0;
    if (op == OP_INSERT) begin
      if (tbl_count >= RULE_ENTRIES) begin
        a.st = ST_FULL;
        return a;
      end
      mk = '0;
      mk[0] = lone_star(k.sta, 5);
      mk[1] = lone_star(40'(k.net), 2);
      mk[2] = lone_star(40'(k.cha), 3);
      mk[3] = k.cha[7:0] == CH_QUEST;
      mk[4] = lone_star(40'(k.loc), 2);
      tbl_key[tbl_count] = k;
      tbl_marks[tbl_count] = mk;
      tbl_map[tbl_count].sta = trim_name(m_raw.sta, 5);
      tbl_map[tbl_count].net = 16'(trim_name(40'(m_raw.net), 2));
      tbl_map[tbl_count].cha = 24'(trim_name(40'(m_raw.cha), 3));
      tbl_map[tbl_count].loc = 16'(trim_name(40'(m_raw.loc), 2));
      tbl_count++;
      return a;
    end
    for (int i = 0; i < tbl_count; i++)
      if (tbl_marks[i] == '0 && tbl_key[i] == k) begin
        a.nm = tbl_map[i];
        return a;
      end
    for (int i = 0; i < tbl_count; i++) begin
      mk = tbl_marks[i];
      if (mk == '0) continue;
      hit = 1'b1;
      if (!mk[0] && tbl_key[i].sta != k.sta) hit = 1'b0;
      if (!mk[1] && tbl_key[i].net != k.net) hit = 1'b0;
      if (!mk[2]) begin
        if (mk[3]) begin
          if (tbl_key[i].cha[23:8] != k.cha[23:8]) hit = 1'b0;
        end else if (tbl_key[i].cha != k.cha) hit = 1'b0;
      end
      if (!mk[4] && tbl_key[i].loc != k.loc) hit = 1'b0;
      if (!hit) continue;
      a.nm.sta = leads_star(tbl_map[i].sta, 5) ? k.sta : tbl_map[i].sta;
      a.nm.net = leads_star(40'(tbl_map[i].net), 2) ? k.net : tbl_map[i].net;
      if (leads_star(40'(tbl_map[i].cha), 3)) a.nm.cha = k.cha;
      else if (tbl_map[i].cha[7:0] == CH_QUEST) a.nm.cha = {tbl_map[i].cha[23:8], k.cha[7:0]};
      else a.nm.cha = tbl_map[i].cha;
      a.nm.loc = leads_star(40'(tbl_map[i].loc), 2) ? k.loc : tbl_map[i].loc;
      return a;
    end
    a.st = ST_NOMATCH;
    return a;
  endfunction

  function automatic names_t mk_names(logic [39:0] s, logic [15:0] n, logic [23:0] c,
                                      logic [15:0] l);
    names_t r;
    r.sta = s;
    r.net = n;
    r.cha = c;
    r.loc = l;
    return r;
  endfunction

  // Draw names mostly from a small alphabet so that rules actually match.
  function automatic logic [39:0] rand_name(int nb);
    logic [39:0] r;
    logic [7:0]  b;
    r = '0;
    case ($urandom_range(0, 7))
      0: r[(nb-1)*8 +: 8] = CH_STAR;
      1: r = 40'({$urandom, $urandom});
      default: begin
        for (int i = 0; i < nb; i++) begin
          case ($urandom_range(0, 9))
            5: b = CH_STAR;
            6: b = CH_QUEST;
            7: b = 8'h00;
            8, 9: b = 8'($urandom_range(0, 255));
            default: b = 8'h41 + 8'($urandom_range(0, 2));
          endcase
          r[i*8 +: 8] = b;
        end
      end
    endcase
    for (int i = nb; i < 5; i++) r[i*8 +: 8] = 8'h00;
    return r;
  endfunction

  function automatic names_t rand_names();
    return mk_names(rand_name(5), 16'(rand_name(2)), 24'(rand_name(3)), 16'(rand_name(2)));
  endfunction

  // Lookup key: mostly a stored key with its wildcard fields filled at random.
  function automatic names_t rand_lookup_key();
    names_t k;
    marks_t mk;
    int     i;
    if (tbl_count == 0 || $urandom_range(0, 3) == 0) return rand_names();
    i = $urandom_range(0, tbl_count - 1);
    k = tbl_key[i];
    mk = tbl_marks[i];
    if (mk[0]) k.sta = rand_name(5);
    if (mk[1]) k.net = 16'(rand_name(2));
    if (mk[2]) k.cha = 24'(rand_name(3));
    else if (mk[3]) k.cha[7:0] = 8'($urandom_range(0, 255));
    if (mk[4]) k.loc = 16'(rand_name(2));
    return k;
  endfunction

  task automatic send_item(opcode_t op, names_t k, names_t m);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    in_opcode <= op;
    {in_key_station, in_key_network, in_key_channel, in_key_location} <= k;
    {in_map_station, in_map_network, in_map_channel, in_map_location} <= m;
    @(posedge clk);
    while (full) @(posedge clk);
    pending_answers.push_back(translate(op, k, m));
  endtask

  // Drop push, then hold until every expected result has come.
  task automatic wait_drained();
    push <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  // Result side: random stalls on pop, compare each beat with the oldest answer.
  initial begin : result_checker
    int      stall;
    answer_t want;
    names_t  got;
    while (!rst_n) @(posedge clk);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      got = mk_names(out_station, out_network, out_channel, out_location);
      if (pending_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat: status %0d", out_status);
      end else begin
        want = pending_answers.pop_front();
        if (out_status != want.st || got != want.nm) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: want st %0d %h %h %h %h, got st %0d %h %h %h %h",
                     want.st, want.nm.sta, want.nm.net, want.nm.cha, want.nm.loc,
                     out_status, got.sta, got.net, got.cha, got.loc);
        end
      end
    end
  end

  task automatic test_directed();
    names_t z;
    z = '0;
    send_item(OP_LOOKUP, mk_names("STA01", "NT", "BHZ", "00"), z);
    send_item(OP_INSERT, mk_names("STA01", "NT", "BHZ", "00"),
              mk_names("NEW01", "XX", "HHZ", "10"));
    // second exact rule on the same key: earliest must win
    send_item(OP_INSERT, mk_names("STA01", "NT", "BHZ", "00"),
              mk_names("LATER", "YY", "LHZ", "20"));
    send_item(OP_LOOKUP, mk_names("STA01", "NT", "BHZ", "00"), z);
    // bytes after a zero are ignored
    send_item(OP_INSERT, mk_names({"AB", 8'h00, "QQ"}, "N\0", {"L", 8'h00, "Z"}, 16'h0),
              mk_names({"*", 8'h00, 8'h00, 8'h00, 8'h00}, 16'h0, 24'h0, 16'h0));
    send_item(OP_LOOKUP, mk_names({"AB", 24'h0}, {"N", 8'hFF}, {"L", 16'h1234}, 16'h0), z);
    // wildcard station, channel match on two chars, pass-through and substitution
    send_item(OP_INSERT, mk_names({"*", 32'h0}, "GE", "BH?", "*\0"),
              mk_names({"*", 32'hFFFF_FFFF}, "*\0", "HH?", "*\0"));
    send_item(OP_LOOKUP, mk_names("ANYST", "GE", "BHN", "01"), z);
    send_item(OP_INSERT, mk_names({"*", 32'h0}, "*\0", "*\0\0", "*\0"),
              mk_names("CATCH", "AL", "LL?", "99"));
    send_item(OP_LOOKUP, mk_names("ANYST", "GE", "BHE", "01"), z);
    send_item(OP_LOOKUP, mk_names("OTHER", "ZZ", "EHZ", "  "), z);
    send_item(OP_INSERT, '1, '1);
    send_item(OP_LOOKUP, '1, z);
    send_item(OP_INSERT, z, z);
    send_item(OP_LOOKUP, z, z);
  endtask

  task automatic test_random_mix(int n);
    for (int i = 0; i < n; i++) begin
      if (i % 150 == 0) quiet = ($urandom_range(0, 2) == 0);
      if ($urandom_range(0, 7) == 0) send_item(OP_INSERT, rand_names(), rand_names());
      else send_item(OP_LOOKUP, rand_lookup_key(), rand_names());
    end
    quiet = 1'b0;
  endtask

  task automatic test_pause_drain();
    wait_drained();
    repeat (10) @(posedge clk);
    send_item(OP_LOOKUP, rand_lookup_key(), '0);
  endtask

  task automatic test_full_table();
    while (tbl_count < RULE_ENTRIES) send_item(OP_INSERT, rand_names(), rand_names());
    for (int i = 0; i < 8; i++) send_item(OP_INSERT, rand_names(), rand_names());
    test_random_mix(300);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random_mix(700);
    test_pause_drain();
    test_random_mix(700);
    test_full_table();
    wait_drained();
    repeat (200) @(posedge clk);
    if (mismatches == 0 && pending_answers.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/cnrt_pkg.sv
hw/rtl/cnrt_front.sv
hw/rtl/cnrt_back.sv
hw/rtl/channel_name_rule_translator_top.sv
hw/rtl/cnrt_checker.sv
tb/sv/channel_name_rule_translator_top_tb.sv
